// ----- rtl/cbm_pkg.sv -----
// Shared types, codes and constants of the cartridge bank mapper.
package cbm_pkg;

    localparam int DEF_MAX_ROM_BANKS = 512;
    localparam int DEF_MAX_RAM_BANKS = 16;
    localparam int CLOCK_REG_COUNT   = 5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 3;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_MBC1 = 3'd1,
        KIND_MBC2 = 3'd2,
        KIND_MBC3 = 3'd3,
        KIND_MBC5 = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        TGT_NONE  = 3'd0,
        TGT_ROM   = 3'd1,
        TGT_XRAM  = 3'd2,
        TGT_M2RAM = 3'd3,
        TGT_CLOCK = 3'd4
    } target_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KIND       = 3'd0,
        CFG_ROM_COUNT  = 3'd1,
        CFG_RAM_COUNT  = 3'd2,
        CFG_RAM_SMALL  = 3'd3,
        CFG_HAS_XRAM   = 3'd4,
        CFG_HAS_CLOCK  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] controller_kind;
        logic [9:0] rom_bank_count;
        logic [4:0] ram_bank_count;
        logic       ram_is_small;
        logic       has_external_ram;
        logic       has_clock;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [22:0] mem_address;
        logic        mem_write;
        logic [7:0]  mem_wdata;
        logic [7:0]  direct_rdata;
        logic        force_high_nibble;
    } result_t;

    localparam logic [3:0] ENABLE_CODE = 4'hA;
    localparam logic [7:0] OPEN_BUS    = 8'hFF;
    localparam logic [7:0] CLOCK_SEL_LO = 8'h08;
    localparam logic [7:0] CLOCK_SEL_HI = 8'h0C;
    localparam logic [9:0] MBC1_BIG_ROM = 10'h020;

endpackage

// ----- rtl/cbm_mapper.sv -----
// Bank state of the selected controller and the address translation of one request.
module cbm_mapper #(
    parameter int MAX_ROM_BANKS = cbm_pkg::DEF_MAX_ROM_BANKS,
    parameter int MAX_RAM_BANKS = cbm_pkg::DEF_MAX_RAM_BANKS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbm_pkg::cfg_t     cfg,
    input  logic              req_valid,
    input  logic              req_write,
    input  logic [15:0]       req_address,
    input  logic [7:0]        req_data,
    output cbm_pkg::result_t  result
);

    localparam int ROM_BANK_W = $clog2(MAX_ROM_BANKS);
    localparam int RAM_BANK_W = (MAX_RAM_BANKS > 1) ? $clog2(MAX_RAM_BANKS) : 1;
    localparam int CLK_SEL_W  = 3;
    localparam logic [ROM_BANK_W-1:0] ROM_LIMIT = ROM_BANK_W'(MAX_ROM_BANKS - 1);
    localparam logic [RAM_BANK_W-1:0] RAM_LIMIT = RAM_BANK_W'(MAX_RAM_BANKS - 1);

    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                  ram_enabled_reg, ram_enabled_next;
    logic                  banking_mode_reg, banking_mode_next;
    logic                  clock_mode_reg, clock_mode_next;
    logic [CLK_SEL_W-1:0]  clock_select_reg, clock_select_next;
    logic                  clock_enabled_reg, clock_enabled_next;
    logic [7:0]            clock_regs_reg [cbm_pkg::CLOCK_REG_COUNT];
    logic                  clock_wr;

    logic [9:0]            rom_cnt_m1;
    logic [4:0]            ram_cnt_m1;
    logic [ROM_BANK_W-1:0] rom_mask;
    logic [RAM_BANK_W-1:0] ram_mask;
    logic [8:0]            rom_bank_x;
    logic [8:0]            rb9;
    logic [8:0]            low_bank;
    logic [3:0]            ram_bank_x;
    logic [6:0]            v7;
    logic [4:0]            v5;
    logic                  en_xram;
    logic                  en_clock;
    logic                  window;
    logic                  ram_ok;
    logic                  in_ram_area;
    logic                  clock_hit;
    logic [12:0]           off;
    logic [7:0]            clock_idx;

    assign rom_cnt_m1 = cfg.rom_bank_count - 10'd1;
    assign ram_cnt_m1 = cfg.ram_bank_count - 5'd1;
    assign rom_mask = (cfg.rom_bank_count == 10'd0) ? '0
                    : (rom_cnt_m1[ROM_BANK_W-1:0] & ROM_LIMIT);
    assign ram_mask = (cfg.ram_bank_count == 5'd0) ? '0
                    : (ram_cnt_m1[RAM_BANK_W-1:0] & RAM_LIMIT);

    assign rom_bank_x = 9'(rom_bank_reg);
    assign ram_bank_x = 4'(ram_bank_reg);
    assign en_xram  = cfg.has_external_ram && (req_data[3:0] == cbm_pkg::ENABLE_CODE);
    assign en_clock = cfg.has_clock && (req_data[3:0] == cbm_pkg::ENABLE_CODE);
    assign v7 = (req_data[6:0] == 7'd0) ? 7'd1 : req_data[6:0];
    assign v5 = (req_data[4:0] == 5'd0) ? 5'd1 : req_data[4:0];

    // The small RAM only answers in the first 2 KiB of the window.
    assign window      = !cfg.ram_is_small || (req_address[12:11] == 2'b00);
    assign ram_ok      = ram_enabled_reg && window;
    assign in_ram_area = (req_address[15:13] == 3'b101);
    assign off         = req_address[12:0];
    assign clock_hit   = clock_mode_reg && clock_enabled_reg
                      && (32'(clock_select_reg) < cbm_pkg::CLOCK_REG_COUNT);
    assign clock_idx   = req_data - cbm_pkg::CLOCK_SEL_LO;
    assign low_bank    = rom_bank_x & 9'h060 & 9'(rom_mask);

    // Control writes into 0000-7FFF.
    always_comb begin
        rom_bank_next      = rom_bank_reg;
        ram_bank_next      = ram_bank_reg;
        ram_enabled_next   = ram_enabled_reg;
        banking_mode_next  = banking_mode_reg;
        clock_mode_next    = clock_mode_reg;
        clock_select_next  = clock_select_reg;
        clock_enabled_next = clock_enabled_reg;
        rb9                = rom_bank_x;
        if (req_valid && req_write && !req_address[15]) begin
            case (cbm_pkg::kind_t'(cfg.controller_kind))
                cbm_pkg::KIND_NONE: begin
                    if (req_address[14:13] == 2'b00) ram_enabled_next = en_xram;
                end
                cbm_pkg::KIND_MBC1: begin
                    case (req_address[14:13])
                        2'b00: ram_enabled_next = en_xram;
                        2'b01: begin
                            rb9 = {4'd0, v5} | (rom_bank_x & 9'h060);
                            rom_bank_next = rb9[ROM_BANK_W-1:0] & rom_mask;
                        end
                        2'b10: begin
                            rb9 = (rom_bank_x & 9'h01F) | {2'b00, req_data[1:0], 5'd0};
                            rom_bank_next = rb9[ROM_BANK_W-1:0] & rom_mask;
                            if (cfg.ram_bank_count > 5'd1) begin
                                ram_bank_next = RAM_BANK_W'({2'b00, req_data[1:0]})
                                              & ram_mask;
                            end
                        end
                        default: banking_mode_next = req_data[0];
                    endcase
                end
                cbm_pkg::KIND_MBC2: begin
                    if (!req_address[14]) begin
                        if (!req_address[8]) begin
                            ram_enabled_next = en_xram;
                        end else if (req_data[3:0] != 4'd0) begin
                            rb9 = {5'd0, req_data[3:0]};
                            rom_bank_next = rb9[ROM_BANK_W-1:0] & rom_mask;
                        end else begin
                            rom_bank_next = ROM_BANK_W'(1);
                        end
                    end
                end
                cbm_pkg::KIND_MBC3: begin
                    case (req_address[14:13])
                        2'b00: begin
                            ram_enabled_next   = en_xram;
                            clock_enabled_next = en_clock;
                        end
                        2'b01: begin
                            rb9 = {2'b00, v7};
                            rom_bank_next = rb9[ROM_BANK_W-1:0] & rom_mask;
                        end
                        2'b10: begin
                            if (req_data >= cbm_pkg::CLOCK_SEL_LO
                                && req_data <= cbm_pkg::CLOCK_SEL_HI) begin
                                clock_select_next = clock_idx[CLK_SEL_W-1:0];
                                clock_mode_next   = 1'b1;
                            end else begin
                                ram_bank_next = RAM_BANK_W'({2'b00, req_data[1:0]})
                                              & ram_mask;
                                clock_mode_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                cbm_pkg::KIND_MBC5: begin
                    case (req_address[14:12])
                        3'b000, 3'b001: ram_enabled_next = en_xram;
                        3'b010: begin
                            rb9 = (rom_bank_x & 9'h100) | {1'b0, req_data};
                            rom_bank_next = rb9[ROM_BANK_W-1:0] & rom_mask;
                        end
                        3'b011: begin
                            rb9 = {req_data[0], rom_bank_x[7:0]};
                            rom_bank_next = rb9[ROM_BANK_W-1:0] & rom_mask;
                        end
                        3'b100, 3'b101: begin
                            ram_bank_next = RAM_BANK_W'(req_data[3:0]) & ram_mask;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Translation of the request into a target and an address.
    always_comb begin
        result             = '0;
        result.target      = cbm_pkg::TGT_NONE;
        clock_wr           = 1'b0;
        if (!req_address[15]) begin
            if (!req_write) begin
                result.target = cbm_pkg::TGT_ROM;
                if (!req_address[14]) begin
                    if ((cbm_pkg::kind_t'(cfg.controller_kind) == cbm_pkg::KIND_MBC1)
                        && banking_mode_reg
                        && (cfg.rom_bank_count > cbm_pkg::MBC1_BIG_ROM)) begin
                        result.mem_address = {low_bank, req_address[13:0]};
                    end else begin
                        result.mem_address = {9'd0, req_address[13:0]};
                    end
                end else begin
                    result.mem_address = {rom_bank_x, req_address[13:0]};
                end
            end
        end else if (in_ram_area) begin
            case (cbm_pkg::kind_t'(cfg.controller_kind))
                cbm_pkg::KIND_NONE: begin
                    if (ram_ok) begin
                        result.target      = cbm_pkg::TGT_XRAM;
                        result.mem_address = 23'(off);
                    end
                end
                cbm_pkg::KIND_MBC1: begin
                    if (ram_ok) begin
                        result.target      = cbm_pkg::TGT_XRAM;
                        result.mem_address = banking_mode_reg ? 23'({ram_bank_x, off})
                                                              : 23'(off);
                    end
                end
                cbm_pkg::KIND_MBC2: begin
                    if (ram_ok) begin
                        result.target            = cbm_pkg::TGT_M2RAM;
                        result.mem_address       = 23'(off[8:0]);
                        result.force_high_nibble = !req_write;
                    end
                end
                cbm_pkg::KIND_MBC3: begin
                    if (!clock_mode_reg) begin
                        if (ram_ok) begin
                            result.target      = cbm_pkg::TGT_XRAM;
                            result.mem_address = 23'({ram_bank_x, off});
                        end
                    end else if (clock_hit) begin
                        result.target      = cbm_pkg::TGT_CLOCK;
                        result.mem_address = 23'(clock_select_reg);
                        clock_wr           = req_write;
                        if (!req_write) begin
                            result.direct_rdata = clock_regs_reg[clock_select_reg];
                        end
                    end
                end
                cbm_pkg::KIND_MBC5: begin
                    if (ram_ok) begin
                        result.target      = cbm_pkg::TGT_XRAM;
                        result.mem_address = 23'({ram_bank_x, off});
                    end
                end
                default: ;
            endcase
            if ((result.target != cbm_pkg::TGT_NONE) && req_write) begin
                result.mem_write = 1'b1;
                result.mem_wdata = req_data;
            end
        end
        if ((result.target == cbm_pkg::TGT_NONE) && !req_write) begin
            result.direct_rdata = cbm_pkg::OPEN_BUS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg      <= ROM_BANK_W'(1);
            ram_bank_reg      <= '0;
            ram_enabled_reg   <= 1'b0;
            banking_mode_reg  <= 1'b0;
            clock_mode_reg    <= 1'b0;
            clock_select_reg  <= '0;
            clock_enabled_reg <= 1'b0;
            for (int i = 0; i < cbm_pkg::CLOCK_REG_COUNT; i++) begin
                clock_regs_reg[i] <= 8'd0;
            end
        end else begin
            rom_bank_reg      <= rom_bank_next;
            ram_bank_reg      <= ram_bank_next;
            ram_enabled_reg   <= ram_enabled_next;
            banking_mode_reg  <= banking_mode_next;
            clock_mode_reg    <= clock_mode_next;
            clock_select_reg  <= clock_select_next;
            clock_enabled_reg <= clock_enabled_next;
            if (req_valid && clock_wr) begin
                clock_regs_reg[clock_select_reg] <= req_data;
            end
        end
    end

endmodule

// ----- rtl/cartridge_bank_mapper.sv -----
// Cartridge bank mapper top level: configuration registers, mapper and output buffer.
//
// The mapper takes one bus request per cycle while s_tready is high and
// registers its result for the master side. Each request is decoded in a
// single pass against the current bank state, so a request sees every control
// write accepted before it. The result side has an output register backed by
// a one-entry skid register: s_tready stays high while the skid register is
// empty, so a stalled result does not stop the next request from entering.
// Configuration is written through the cfg port, which is always ready, and
// must only be written while no request is in flight.
module cartridge_bank_mapper #(
    parameter int MAX_ROM_BANKS = cbm_pkg::DEF_MAX_ROM_BANKS,
    parameter int MAX_RAM_BANKS = cbm_pkg::DEF_MAX_RAM_BANKS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cbm_pkg::S_TDATA_W-1:0]     s_tdata,  // bus_address, bus_data
    input  logic                              s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // mem_address, mem_write, mem_wdata, direct_rdata, force_high_nibble, zero fill
    output logic [cbm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [cbm_pkg::M_TUSER_W-1:0]     m_tuser,  // target
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    cbm_pkg::cfg_t    cfg_reg;
    cbm_pkg::result_t result;
    cbm_pkg::result_t out_reg;
    cbm_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.controller_kind  <= cbm_pkg::KIND_NONE;
            cfg_reg.rom_bank_count   <= 10'd2;
            cfg_reg.ram_bank_count   <= 5'd0;
            cfg_reg.ram_is_small     <= 1'b0;
            cfg_reg.has_external_ram <= 1'b0;
            cfg_reg.has_clock        <= 1'b0;
        end else if (cfg_valid) begin
            case (cbm_pkg::cfg_index_t'(cfg_index))
                cbm_pkg::CFG_KIND:      cfg_reg.controller_kind  <= cfg_data[2:0];
                cbm_pkg::CFG_ROM_COUNT: cfg_reg.rom_bank_count   <= cfg_data[9:0];
                cbm_pkg::CFG_RAM_COUNT: cfg_reg.ram_bank_count   <= cfg_data[4:0];
                cbm_pkg::CFG_RAM_SMALL: cfg_reg.ram_is_small     <= cfg_data[0];
                cbm_pkg::CFG_HAS_XRAM:  cfg_reg.has_external_ram <= cfg_data[0];
                cbm_pkg::CFG_HAS_CLOCK: cfg_reg.has_clock        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cbm_mapper #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS),
        .MAX_RAM_BANKS (MAX_RAM_BANKS)
    ) u_mapper (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .req_valid   (s_accept),
        .req_write   (s_tuser),
        .req_address (s_tdata[15:0]),
        .req_data    (s_tdata[23:16]),
        .result      (result)
    );

    // The skid register only fills while the output register is held.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= result;
            end
        end else if (s_accept) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.target;
    assign m_tdata  = {7'd0, out_reg.force_high_nibble, out_reg.direct_rdata,
                       out_reg.mem_wdata, out_reg.mem_write, out_reg.mem_address};

endmodule

// ----- verif/cbm_checker.sv -----
`timescale 1ns / 1ps
// Bank mapper checker: tracks configuration and bus requests, predicts each result and compares.
module cbm_checker
    import cbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [M_TUSER_W-1:0]   m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     results_due
);

    // Cartridge setup.
    logic [2:0] kind;
    logic [9:0] rom_banks;
    logic [4:0] ram_count;
    logic       ram_small;
    logic       has_xram;
    logic       has_rtc;

    // Bank state.
    logic [8:0] rom_bank;
    logic [3:0] ram_bank;
    logic       ram_on;
    logic       bank_mode;
    logic       rtc_mode;
    logic [2:0] rtc_sel;
    logic       rtc_on;
    logic [7:0] rtc_regs [CLOCK_REG_COUNT];

    result_t pending_results [$];
    int      fail_count = 0;

    assign errors = fail_count;

    function automatic logic [8:0] rom_mask();
        return (rom_banks == 10'd0) ? 9'd0 : 9'(rom_banks - 10'd1);
    endfunction

    function automatic logic [3:0] ram_mask();
        return (ram_count == 5'd0) ? 4'd0 : 4'(ram_count - 5'd1);
    endfunction

    function automatic logic enable_from(logic present, logic [7:0] d);
        return present && (d[3:0] == ENABLE_CODE);
    endfunction

    function automatic void reset_state();
        kind      = KIND_NONE;
        rom_banks = 10'd2;
        ram_count = 5'd0;
        ram_small = 1'b0;
        has_xram  = 1'b0;
        has_rtc   = 1'b0;
        rom_bank  = 9'd1;
        ram_bank  = 4'd0;
        ram_on    = 1'b0;
        bank_mode = 1'b0;
        rtc_mode  = 1'b0;
        rtc_sel   = 3'd0;
        rtc_on    = 1'b0;
        for (int i = 0; i < CLOCK_REG_COUNT; i++) rtc_regs[i] = 8'd0;
    endfunction

    function automatic void control_write(logic [15:0] a, logic [7:0] d);
        logic [4:0] low5;
        logic [6:0] low7;
        case (kind)
            KIND_NONE: begin
                if (a <= 16'h1FFF) ram_on = enable_from(has_xram, d);
            end
            KIND_MBC1: begin
                if (a <= 16'h1FFF) begin
                    ram_on = enable_from(has_xram, d);
                end else if (a <= 16'h3FFF) begin
                    low5 = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
                    rom_bank = {2'b00, rom_bank[6:5], low5} & rom_mask();
                end else if (a <= 16'h5FFF) begin
                    rom_bank = {2'b00, d[1:0], rom_bank[4:0]} & rom_mask();
                    if (ram_count > 5'd1) ram_bank = {2'b00, d[1:0]} & ram_mask();
                end else begin
                    bank_mode = d[0];
                end
            end
            KIND_MBC2: begin
                // Address bit 8 picks between RAM enable and ROM bank select.
                if (a <= 16'h3FFF) begin
                    if (!a[8]) ram_on = enable_from(has_xram, d);
                    else if (d[3:0] != 4'd0) rom_bank = {5'd0, d[3:0]} & rom_mask();
                    else rom_bank = 9'd1;
                end
            end
            KIND_MBC3: begin
                if (a <= 16'h1FFF) begin
                    ram_on = enable_from(has_xram, d);
                    rtc_on = enable_from(has_rtc, d);
                end else if (a <= 16'h3FFF) begin
                    low7 = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
                    rom_bank = {2'b00, low7} & rom_mask();
                end else if (a <= 16'h5FFF) begin
                    if (d >= CLOCK_SEL_LO && d <= CLOCK_SEL_HI) begin
                        rtc_sel  = 3'(d - CLOCK_SEL_LO);
                        rtc_mode = 1'b1;
                    end else begin
                        ram_bank = {2'b00, d[1:0]} & ram_mask();
                        rtc_mode = 1'b0;
                    end
                end
            end
            KIND_MBC5: begin
                if (a <= 16'h1FFF) ram_on = enable_from(has_xram, d);
                else if (a <= 16'h2FFF) rom_bank = {rom_bank[8], d} & rom_mask();
                else if (a <= 16'h3FFF) rom_bank = {d[0], rom_bank[7:0]} & rom_mask();
                else if (a <= 16'h5FFF) ram_bank = d[3:0] & ram_mask();
            end
            default: ;
        endcase
    endfunction

    function automatic result_t map_access(logic wr, logic [15:0] a, logic [7:0] d);
        result_t     res;
        int unsigned addr;
        int unsigned off;
        logic        ram_ok;
        res    = '0;
        addr   = 0;
        off    = 32'(a) - 32'hA000;
        ram_ok = ram_on && (!ram_small || a <= 16'hA7FF);
        if (a <= 16'h7FFF) begin
            if (wr) begin
                control_write(a, d);
            end else if (a <= 16'h3FFF) begin
                res.target = TGT_ROM;
                addr = 32'(a);
                // Large MBC1 carts in mode 1 also bank the fixed low area.
                if (kind == KIND_MBC1 && bank_mode && rom_banks > MBC1_BIG_ROM)
                    addr = 32'(a) + 32'(rom_bank & 9'h060 & rom_mask()) * 32'h4000;
            end else begin
                res.target = TGT_ROM;
                addr = 32'(a) - 32'h4000 + 32'(rom_bank) * 32'h4000;
            end
        end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
            case (kind)
                KIND_NONE: begin
                    if (ram_ok) begin
                        res.target = TGT_XRAM;
                        addr = off;
                    end
                end
                KIND_MBC1: begin
                    if (ram_ok) begin
                        res.target = TGT_XRAM;
                        addr = bank_mode ? off + 32'(ram_bank) * 32'h2000 : off;
                    end
                end
                KIND_MBC2: begin
                    if (ram_ok) begin
                        res.target = TGT_M2RAM;
                        addr = off & 32'h1FF;
                        res.force_high_nibble = !wr;
                    end
                end
                KIND_MBC3: begin
                    if (!rtc_mode) begin
                        if (ram_ok) begin
                            res.target = TGT_XRAM;
                            addr = off + 32'(ram_bank) * 32'h2000;
                        end
                    end else if (rtc_on && rtc_sel < CLOCK_REG_COUNT) begin
                        res.target = TGT_CLOCK;
                        addr = 32'(rtc_sel);
                        if (wr) rtc_regs[rtc_sel] = d;
                        else res.direct_rdata = rtc_regs[rtc_sel];
                    end
                end
                KIND_MBC5: begin
                    if (ram_ok) begin
                        res.target = TGT_XRAM;
                        addr = off + 32'(ram_bank) * 32'h2000;
                    end
                end
                default: ;
            endcase
            if (res.target != TGT_NONE && wr) begin
                res.mem_write = 1'b1;
                res.mem_wdata = d;
            end
        end
        if (res.target == TGT_NONE && !wr) res.direct_rdata = OPEN_BUS;
        res.mem_address = addr[22:0];
        return res;
    endfunction

    task automatic compare_field(string what, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, seen);
            fail_count++;
        end
    endtask

    initial reset_state();

    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        if (!aresetn) begin
            reset_state();
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KIND:      kind      = cfg_data[2:0];
                    CFG_ROM_COUNT: rom_banks = cfg_data;
                    CFG_RAM_COUNT: ram_count = cfg_data[4:0];
                    CFG_RAM_SMALL: ram_small = cfg_data[0];
                    CFG_HAS_XRAM:  has_xram  = cfg_data[0];
                    CFG_HAS_CLOCK: has_rtc   = cfg_data[0];
                    default: ;
                endcase
            end
            // Results are checked before this edge's request is predicted, so a
            // result that shows up with nothing outstanding is always caught.
            if (m_tvalid && m_tready) begin
                seen.target            = m_tuser;
                seen.mem_address       = m_tdata[22:0];
                seen.mem_write         = m_tdata[23];
                seen.mem_wdata         = m_tdata[31:24];
                seen.direct_rdata      = m_tdata[39:32];
                seen.force_high_nibble = m_tdata[40];
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no request outstanding, got target 0x%0h",
                             $time, seen.target);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("target", 32'(want.target), 32'(seen.target));
                    compare_field("mem_address", 32'(want.mem_address),
                                  32'(seen.mem_address));
                    compare_field("mem_write", 32'(want.mem_write), 32'(seen.mem_write));
                    compare_field("mem_wdata", 32'(want.mem_wdata), 32'(seen.mem_wdata));
                    compare_field("direct_rdata", 32'(want.direct_rdata),
                                  32'(seen.direct_rdata));
                    compare_field("force_high_nibble", 32'(want.force_high_nibble),
                                  32'(seen.force_high_nibble));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
        end
        results_due <= pending_results.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the cartridge bank mapper: clock, reset, stimulus and verdict.
module tb_top;
    import cbm_pkg::*;

    // Register slots past the defined list, and controller kinds with no mapper.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int PHASES = 12;
    localparam int PHASE_REQUESTS = 105;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int errors;
    int results_due;
    bit calm = 1'b0;  // when set, neither side idles

    always #1 aclk = ~aclk;

    cartridge_bank_mapper u_top (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    cbm_checker u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .results_due
    );

    task automatic send_access(logic wr, logic [15:0] a, logic [7:0] d);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, a};
        s_tuser  <= wr;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits until every outstanding request has its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic setup_cart(logic [2:0] kind, logic [9:0] roms, logic [4:0] rams,
                              logic small_ram, logic xram, logic rtc);
        write_reg(CFG_KIND, 10'(kind));
        write_reg(CFG_ROM_COUNT, roms);
        write_reg(CFG_RAM_COUNT, 10'(rams));
        write_reg(CFG_RAM_SMALL, 10'(small_ram));
        write_reg(CFG_HAS_XRAM, 10'(xram));
        write_reg(CFG_HAS_CLOCK, 10'(rtc));
        cfg_valid <= 1'b0;
    endtask

    // Mostly meaningful traffic: bank writes, ROM reads and RAM window accesses.
    task automatic random_access();
        int          pick;
        int          sel;
        logic        wr;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        d    = 8'($urandom_range(0, 255));
        if (pick < 25) begin
            wr  = 1'b1;
            a   = 16'($urandom_range(0, 16'h7FFF));
            sel = $urandom_range(0, 9);
            if (sel < 4) d = {d[7:4], ENABLE_CODE};
            else if (sel < 6) d = 8'($urandom_range(CLOCK_SEL_LO, CLOCK_SEL_HI));
        end else if (pick < 55) begin
            wr = 1'b0;
            a  = 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 90) begin
            wr = 1'($urandom_range(0, 1));
            a  = 16'($urandom_range(16'hA000, 16'hBFFF));
        end else begin
            wr = 1'($urandom_range(0, 1));
            a  = 16'($urandom_range(0, 16'hFFFF));
        end
        send_access(wr, a, d);
    endtask

    // Result side: a random stall before each result, none while calm.
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [2:0] kinds [PHASES];
        logic [9:0] roms [PHASES];
        logic [4:0] rams [PHASES];
        kinds = '{KIND_MBC1, KIND_MBC3, KIND_MBC5, KIND_MBC2,
                  KIND_NONE, KIND_MBC1, KIND_MBC3, KIND_SPARE_5,
                  KIND_MBC5, KIND_MBC1, KIND_SPARE_7, KIND_MBC3};
        roms  = '{10'd512, 10'd64, 10'd512, 10'd16, 10'd2, 10'd32,
                  10'd128, 10'd8, 10'd0, 10'd1023, 10'd4, 10'd3};
        rams  = '{5'd4, 5'd16, 5'd16, 5'd1, 5'd1, 5'd0,
                  5'd4, 5'd8, 5'd31, 5'd16, 5'd5, 5'd0};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default setup straight out of reset.
        send_access(1'b0, 16'h0000, 8'h00);
        send_access(1'b0, 16'h7FFF, 8'h00);
        send_access(1'b1, 16'h0000, 8'h0A);
        send_access(1'b0, 16'hA000, 8'h00);
        drain();

        // Large MBC1 cart; indexes past the list must change nothing.
        write_reg(CFG_SPARE_LO, 10'h3FF);
        write_reg(CFG_SPARE_HI, 10'h001);
        setup_cart(KIND_MBC1, 10'd64, 5'd4, 1'b0, 1'b1, 1'b0);
        send_access(1'b0, 16'h3FFF, 8'h00);
        send_access(1'b1, 16'h2000, 8'h00);
        send_access(1'b1, 16'h4000, 8'hFF);
        send_access(1'b0, 16'h4000, 8'h00);
        send_access(1'b1, 16'h6000, 8'h01);
        send_access(1'b0, 16'h0000, 8'h00);
        send_access(1'b1, 16'h1FFF, 8'hFA);
        send_access(1'b1, 16'hBFFF, 8'hFF);
        send_access(1'b0, 16'hA000, 8'h00);
        send_access(1'b0, 16'h8000, 8'h00);
        send_access(1'b0, 16'hFFFF, 8'h00);
        send_access(1'b1, 16'hC000, 8'h5A);
        drain();

        // Clock registers on an MBC3 cart, reachable without RAM enable.
        setup_cart(KIND_MBC3, 10'd128, 5'd4, 1'b1, 1'b0, 1'b1);
        send_access(1'b1, 16'h0000, 8'h0A);
        send_access(1'b1, 16'h4000, 8'h08);
        send_access(1'b1, 16'hB000, 8'h55);
        send_access(1'b1, 16'h5FFF, 8'h0C);
        send_access(1'b1, 16'hBFFF, 8'hA5);
        send_access(1'b0, 16'hBFFF, 8'h00);
        send_access(1'b1, 16'h7000, 8'h01);
        send_access(1'b1, 16'h0000, 8'h00);
        send_access(1'b0, 16'hA000, 8'h00);
        send_access(1'b1, 16'hA000, 8'h11);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            setup_cart(kinds[p], roms[p], rams[p], p % 4 == 2, p != 4,
                       (p % 5 != 3) && (p != 11));
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                if ($urandom_range(0, 39) == 0) calm = !calm;
                random_access();
            end
            drain();
        end

        s_tvalid <= 1'b0;
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cbm_pkg.sv
rtl/cbm_mapper.sv
rtl/cartridge_bank_mapper.sv
verif/cbm_checker.sv
verif/tb_top.sv
